// ----- rtl/rabin_encrypt_decrypt_macros.svh -----
// Assertion macros for the Rabin cipher block.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef RABIN_ENCRYPT_DECRYPT_MACROS_SVH
`define RABIN_ENCRYPT_DECRYPT_MACROS_SVH

// same-cycle implication
`define RED_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/red_pkg.sv -----
// Shared widths, register codes and handshake structs for the Rabin cipher block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package red_pkg;

   localparam int PRIME_BITS = 16;
   localparam int MSG_BITS   = 16;

   localparam int P_W    = (PRIME_BITS < 16) ? PRIME_BITS : 16;
   localparam int N_W    = 2 * P_W;
   localparam int MUL_W  = (N_W > 32) ? N_W : 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CNT_W  = $clog2(PROD_W);
   localparam int E_W    = 2 * MSG_BITS;
   localparam int COEF_W = P_W + 3;
   localparam int DATA_W = 32;
   localparam int ROOT_W = 33;
   localparam int HALF_W = 16;
   localparam int CFG_W  = 16;
   localparam int IDX_W  = 2;

   localparam logic [IDX_W-1:0] REG_PRIME_P = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_PRIME_Q = IDX_W'(1);

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic [CFG_W-1:0] PRIME_P_RESET = CFG_W'(23);
   localparam logic [CFG_W-1:0] PRIME_Q_RESET = CFG_W'(11);

   typedef struct packed {
      logic              start;
      logic              mul_en;
      logic              div_en;
      logic [MUL_W-1:0]  a;
      logic [MUL_W-1:0]  b;
      logic [PROD_W-1:0] dvd;
      logic [MUL_W-1:0]  m;
   } red_cmd_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quo;
      logic [MUL_W-1:0]  rem;
   } red_ares_type;

   typedef struct packed {
      logic              valid;
      logic              op;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] k;
      logic [P_W-1:0]    p;
      logic [P_W-1:0]    q;
   } red_job_type;

   typedef struct packed {
      logic idle;
      logic done;
   } red_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] cipher_out;
      logic [DATA_W-1:0] quotient_out;
      logic [ROOT_W-1:0] root_r;
      logic [ROOT_W-1:0] root_s;
      logic [ROOT_W-1:0] root_t;
      logic [ROOT_W-1:0] root_u;
      logic [HALF_W-1:0] message_out;
      logic              msg_valid;
   } red_result_type;

endpackage

// ----- rtl/red_ifs.sv -----
// Request, response and register-write channel interfaces of the Rabin cipher block.
// Depends on red_pkg for payload widths.
`timescale 1ns / 1ps
interface red_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [red_pkg::DATA_W-1:0] data_in;
   logic [red_pkg::DATA_W-1:0] quotient_in;
   modport source (output valid, op, data_in, quotient_in, input ready);
   modport sink (input valid, op, data_in, quotient_in, output ready);
endinterface

interface red_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [red_pkg::DATA_W-1:0] cipher_out;
   logic [red_pkg::DATA_W-1:0] quotient_out;
   logic [red_pkg::ROOT_W-1:0] root_r;
   logic [red_pkg::ROOT_W-1:0] root_s;
   logic [red_pkg::ROOT_W-1:0] root_t;
   logic [red_pkg::ROOT_W-1:0] root_u;
   logic [red_pkg::HALF_W-1:0] message_out;
   logic                       msg_valid;
   modport source (output valid, cipher_out, quotient_out, root_r, root_s, root_t, root_u,
                   message_out, msg_valid, input ready);
   modport sink (input valid, cipher_out, quotient_out, root_r, root_s, root_t, root_u,
                 message_out, msg_valid, output ready);
endinterface

interface red_csr_if;
   logic                      valid;
   logic                      ready;
   logic [red_pkg::IDX_W-1:0] index;
   logic [red_pkg::CFG_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rabin_encrypt_decrypt.sv -----
// Top level of the Rabin cipher block: prime registers, channel handshakes, result register.
// Depends on red_pkg, red_ifs, red_ctrl and the assertion macro header.
//
//   channel  direction  carries
//   req_ch   in         op, data_in, quotient_in
//   rsp_ch   out        cipher_out, quotient_out, root_r..root_u, message_out, msg_valid
//   csr_ch   in         index, data (prime_p at index 0, prime_q at index 1)
//
// Encrypt runs two products and two 64-step restoring divisions.
// In decrypt, each Euclid step and each modular product of
// the two square-root powers is a 64-step division on the one shared divide unit.
// A zero modulus goes to the result straight after the product p*q. Reset is synchronous; no clearing pass.
// req_ch is not ready while a request is in work; the result register frees the
// sequencer as soon as rsp_ch takes the previous result. csr_ch is always ready.
`timescale 1ns / 1ps
`include "rabin_encrypt_decrypt_macros.svh"
module rabin_encrypt_decrypt (
   input logic       clock,
   input logic       reset,
   red_req_if.sink   req_ch,
   red_rsp_if.source rsp_ch,
   red_csr_if.sink   csr_ch
);
   import red_pkg::*;

   logic [CFG_W-1:0] prime_p_ff;
   logic [CFG_W-1:0] prime_q_ff;
   logic             rsp_valid_ff;
   red_result_type   rsp_data_ff;
   red_job_type      job;
   red_status_type   status;
   red_result_type   result;
   logic             take;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_p_ff <= PRIME_P_RESET;
         prime_q_ff <= PRIME_Q_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_PRIME_P: prime_p_ff <= csr_ch.data;
            REG_PRIME_Q: prime_q_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = status.idle;
   assign job.valid    = req_ch.valid & status.idle;
   assign job.op       = req_ch.op;
   assign job.data     = req_ch.data_in;
   assign job.k        = req_ch.quotient_in;
   assign job.p        = prime_p_ff[P_W-1:0];
   assign job.q        = prime_q_ff[P_W-1:0];

   assign take = status.done & (~rsp_valid_ff | rsp_ch.ready);

   red_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .job_i    (job),
      .take_i   (take),
      .status_o (status),
      .result_o (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_data_ff <= result;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.cipher_out   = rsp_data_ff.cipher_out;
   assign rsp_ch.quotient_out = rsp_data_ff.quotient_out;
   assign rsp_ch.root_r       = rsp_data_ff.root_r;
   assign rsp_ch.root_s       = rsp_data_ff.root_s;
   assign rsp_ch.root_t       = rsp_data_ff.root_t;
   assign rsp_ch.root_u       = rsp_data_ff.root_u;
   assign rsp_ch.message_out  = rsp_data_ff.message_out;
   assign rsp_ch.msg_valid    = rsp_data_ff.msg_valid;

   `RED_ASSERT_NEXT(a_busy_after_req, req_ch.valid && req_ch.ready, !req_ch.ready, "ready after request")
   `RED_ASSERT_NOW(a_msg_zero, rsp_ch.valid && !rsp_ch.msg_valid, rsp_ch.message_out == '0, "message without match")
   `RED_ASSERT_NOW(a_rsp_from_work, $rose(rsp_ch.valid), $past(!req_ch.ready), "result without request")

endmodule

// ----- rtl/red_arith.sv -----
// Shared multiply and restoring-divide unit: a*b alone, or (a*b or dividend) / m, one quotient bit a cycle.
// Depends on red_pkg.
`timescale 1ns / 1ps
module red_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  red_pkg::red_cmd_type  cmd_i,
   output red_pkg::red_ares_type res_o
);
   import red_pkg::*;

   typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} state_type;

   typedef struct packed {
      state_type         state;
      logic              mul_en;
      logic              div_en;
      logic [MUL_W-1:0]  a;
      logic [MUL_W-1:0]  b;
      logic [PROD_W-1:0] dvd;
      logic [MUL_W-1:0]  m;
      logic [MUL_W-1:0]  rem;
      logic [PROD_W-1:0] quo;
      logic [CNT_W-1:0]  cnt;
      logic              done;
   } regs_type;

   regs_type regs_ff, regs_in;

   always_comb begin
      logic [MUL_W:0] sh;
      logic           ge;
      regs_in      = regs_ff;
      regs_in.done = 1'b0;
      sh = {regs_ff.rem, regs_ff.quo[PROD_W-1]};
      ge = (sh >= {1'b0, regs_ff.m});
      unique case (regs_ff.state)
         A_IDLE: begin
            if (cmd_i.start) begin
               regs_in.mul_en = cmd_i.mul_en;
               regs_in.div_en = cmd_i.div_en;
               regs_in.a      = cmd_i.a;
               regs_in.b      = cmd_i.b;
               regs_in.dvd    = cmd_i.dvd;
               regs_in.m      = cmd_i.m;
               regs_in.state  = A_MUL;
            end
         end
         A_MUL: begin
            regs_in.quo = regs_ff.mul_en ? regs_ff.a * regs_ff.b : regs_ff.dvd;
            regs_in.rem = '0;
            regs_in.cnt = '0;
            if (regs_ff.div_en) begin
               regs_in.state = A_DIV;
            end else begin
               regs_in.done  = 1'b1;
               regs_in.state = A_IDLE;
            end
         end
         A_DIV: begin
            regs_in.rem = ge ? MUL_W'(sh - {1'b0, regs_ff.m}) : sh[MUL_W-1:0];
            regs_in.quo = {regs_ff.quo[PROD_W-2:0], ge};
            regs_in.cnt = regs_ff.cnt + CNT_W'(1);
            if (regs_ff.cnt == CNT_W'(PROD_W - 1)) begin
               regs_in.done  = 1'b1;
               regs_in.state = A_IDLE;
            end
         end
         default: regs_in.state = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.state <= A_IDLE;
         regs_ff.done  <= 1'b0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign res_o.done = regs_ff.done;
   assign res_o.quo  = regs_ff.quo;
   assign res_o.rem  = regs_ff.rem;

endmodule

// ----- rtl/red_ctrl.sv -----
// Sequencer for encrypt and decrypt: Euclid, modular powers, CRT and halves test.
// Depends on red_pkg and drives red_arith.
`timescale 1ns / 1ps
module red_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  red_pkg::red_job_type    job_i,
   input  logic                    take_i,
   output red_pkg::red_status_type status_o,
   output red_pkg::red_result_type result_o
);
   import red_pkg::*;

   localparam int LEN_W = $clog2(MSG_BITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_N, ST_ENC_DIV, ST_ENC_SQ, ST_EU_TEST, ST_EU_DIV, ST_EU_MX, ST_EU_MY,
      ST_PW_BASE, ST_PW_TEST, ST_PW_MUL, ST_PW_SQ, ST_CX, ST_CY, ST_TP1, ST_TP2,
      ST_TQ1, ST_TQ2, ST_COMB, ST_KN, ST_HALF, ST_DONE
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [HALF_W-1:0] half;
   } half_type;

   typedef struct packed {
      state_type                     state;
      logic                          pend;
      red_cmd_type                   cmd;
      logic                          op;
      logic [DATA_W-1:0]             data;
      logic [DATA_W-1:0]             k;
      logic [P_W-1:0]                p;
      logic [P_W-1:0]                q;
      logic [N_W-1:0]                n;
      logic [P_W-1:0]                ea;
      logic [P_W-1:0]                eb;
      logic [P_W-1:0]                z;
      logic [COEF_W-1:0]             x;
      logic [COEF_W-1:0]             y;
      logic [COEF_W-1:0]             lx;
      logic [COEF_W-1:0]             ly;
      logic                          sel_q;
      logic [P_W-1:0]                acc;
      logic [P_W-1:0]                base;
      logic [P_W-1:0]                ex;
      logic [P_W-1:0]                mp;
      logic [P_W-1:0]                mq;
      logic [N_W-1:0]                cx;
      logic [N_W-1:0]                cy;
      logic [N_W-1:0]                t1;
      logic [N_W-1:0]                tp;
      logic [N_W-1:0]                tq;
      logic [3:0][ROOT_W-1:0]        roots;
      logic [1:0]                    hidx;
      red_result_type                res;
   } regs_type;

   regs_type     regs_ff, regs_in;
   red_ares_type ares;

   function automatic logic [E_W-1:0] expand(logic [MSG_BITS-1:0] m);
      logic [LEN_W-1:0] len;
      len = '0;
      for (int i = 0; i < MSG_BITS; i++) begin
         if (m[i]) len = LEN_W'(i + 1);
      end
      return (E_W'(m) << len) | E_W'(m);
   endfunction

   function automatic half_type halves(logic [ROOT_W-1:0] root);
      half_type hr;
      hr = '0;
      for (int h = 1; h <= ROOT_W / 2; h++) begin
         if (root[2*h-1] && ((root >> (2 * h)) == '0) &&
             ((root & ((ROOT_W'(1) << h) - ROOT_W'(1))) == (root >> h))) begin
            hr.hit  = 1'b1;
            hr.half = HALF_W'(root >> h);
         end
      end
      return hr;
   endfunction

   function automatic logic [COEF_W-1:0] coef_abs(logic [COEF_W-1:0] v);
      return v[COEF_W-1] ? COEF_W'(-$signed(v)) : v;
   endfunction

   function automatic logic [COEF_W-1:0] coef_update(logic [COEF_W-1:0] last,
                                                     logic [COEF_W-1:0] cur,
                                                     logic [COEF_W-1:0] prod);
      logic [COEF_W-1:0] sp;
      sp = cur[COEF_W-1] ? COEF_W'(-$signed(prod)) : prod;
      return COEF_W'($signed(last) - $signed(sp));
   endfunction

   function automatic logic [N_W-1:0] signed_mod(logic neg, logic [N_W-1:0] r,
                                                 logic [N_W-1:0] n);
      if (!neg || r == '0) return r;
      return n - r;
   endfunction

   always_comb begin
      logic [P_W-1:0] mod;
      logic [N_W:0]   sum_r;
      logic [N_W-1:0] rr;
      logic [N_W-1:0] tt;
      logic [ROOT_W-1:0] kn;
      half_type       hr;
      regs_in           = regs_ff;
      regs_in.cmd.start = 1'b0;
      mod   = regs_ff.sel_q ? regs_ff.q : regs_ff.p;
      sum_r = {1'b0, regs_ff.tp} + {1'b0, regs_ff.tq};
      rr    = (sum_r >= {1'b0, regs_ff.n}) ? N_W'(sum_r - {1'b0, regs_ff.n}) : sum_r[N_W-1:0];
      tt    = (regs_ff.tq >= regs_ff.tp) ? regs_ff.tq - regs_ff.tp
                                          : regs_ff.tq + (regs_ff.n - regs_ff.tp);
      kn    = ares.quo[ROOT_W-1:0];
      hr    = halves(regs_ff.roots[regs_ff.hidx]);
      unique case (regs_ff.state)
         ST_IDLE: begin
            if (job_i.valid) begin
               regs_in.op    = job_i.op;
               regs_in.data  = job_i.data;
               regs_in.k     = job_i.k;
               regs_in.p     = job_i.p;
               regs_in.q     = job_i.q;
               regs_in.res   = '0;
               regs_in.pend  = 1'b0;
               regs_in.state = ST_N;
            end
         end
         ST_N: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b0, MUL_W'(regs_ff.p), MUL_W'(regs_ff.q),
                                '0, '0};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.n     = ares.quo[N_W-1:0];
               regs_in.ea    = regs_ff.p;
               regs_in.eb    = regs_ff.q;
               regs_in.x     = '0;
               regs_in.y     = COEF_W'(1);
               regs_in.lx    = COEF_W'(1);
               regs_in.ly    = '0;
               regs_in.sel_q = 1'b0;
               if (ares.quo[N_W-1:0] == '0) regs_in.state = ST_DONE;
               else if (regs_ff.op == OP_DECRYPT) regs_in.state = ST_EU_TEST;
               else regs_in.state = ST_ENC_DIV;
            end
         end
         ST_ENC_DIV: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b0, 1'b1, '0, '0,
                                PROD_W'(expand(regs_ff.data[MSG_BITS-1:0])),
                                MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend             = 1'b0;
               regs_in.res.quotient_out = ares.quo[DATA_W-1:0];
               regs_in.t1               = ares.rem[N_W-1:0];
               regs_in.state            = ST_ENC_SQ;
            end
         end
         ST_ENC_SQ: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.t1), MUL_W'(regs_ff.t1),
                                '0, MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend           = 1'b0;
               regs_in.res.cipher_out = DATA_W'(ares.rem);
               regs_in.state          = ST_DONE;
            end
         end
         ST_EU_TEST: begin
            regs_in.state = (regs_ff.eb == '0) ? ST_PW_BASE : ST_EU_DIV;
         end
         ST_EU_DIV: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b0, 1'b1, '0, '0, PROD_W'(regs_ff.ea),
                                MUL_W'(regs_ff.eb)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.z     = ares.quo[P_W-1:0];
               regs_in.ea    = regs_ff.eb;
               regs_in.eb    = ares.rem[P_W-1:0];
               regs_in.state = ST_EU_MX;
            end
         end
         ST_EU_MX: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b0, MUL_W'(regs_ff.z),
                                MUL_W'(coef_abs(regs_ff.x)), '0, '0};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.x     = coef_update(regs_ff.lx, regs_ff.x, ares.quo[COEF_W-1:0]);
               regs_in.lx    = regs_ff.x;
               regs_in.state = ST_EU_MY;
            end
         end
         ST_EU_MY: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b0, MUL_W'(regs_ff.z),
                                MUL_W'(coef_abs(regs_ff.y)), '0, '0};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.y     = coef_update(regs_ff.ly, regs_ff.y, ares.quo[COEF_W-1:0]);
               regs_in.ly    = regs_ff.y;
               regs_in.state = ST_EU_TEST;
            end
         end
         ST_PW_BASE: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b0, 1'b1, '0, '0, PROD_W'(regs_ff.data),
                                MUL_W'(mod)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.base  = ares.rem[P_W-1:0];
               regs_in.acc   = (mod == P_W'(1)) ? '0 : P_W'(1);
               regs_in.ex    = P_W'(({1'b0, mod} + (P_W + 1)'(1)) >> 2);
               regs_in.state = ST_PW_TEST;
            end
         end
         ST_PW_TEST: begin
            if (regs_ff.ex == '0) begin
               if (!regs_ff.sel_q) begin
                  regs_in.mp    = regs_ff.acc;
                  regs_in.sel_q = 1'b1;
                  regs_in.state = ST_PW_BASE;
               end else begin
                  regs_in.mq    = regs_ff.acc;
                  regs_in.state = ST_CX;
               end
            end else begin
               regs_in.state = regs_ff.ex[0] ? ST_PW_MUL : ST_PW_SQ;
            end
         end
         ST_PW_MUL: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.acc), MUL_W'(regs_ff.base),
                                '0, MUL_W'(mod)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.acc   = ares.rem[P_W-1:0];
               regs_in.state = ST_PW_SQ;
            end
         end
         ST_PW_SQ: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.base), MUL_W'(regs_ff.base),
                                '0, MUL_W'(mod)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.base  = ares.rem[P_W-1:0];
               regs_in.ex    = regs_ff.ex >> 1;
               regs_in.state = ST_PW_TEST;
            end
         end
         ST_CX: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b0, 1'b1, '0, '0, PROD_W'(coef_abs(regs_ff.lx)),
                                MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.cx    = signed_mod(regs_ff.lx[COEF_W-1], ares.rem[N_W-1:0], regs_ff.n);
               regs_in.state = ST_CY;
            end
         end
         ST_CY: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b0, 1'b1, '0, '0, PROD_W'(coef_abs(regs_ff.ly)),
                                MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.cy    = signed_mod(regs_ff.ly[COEF_W-1], ares.rem[N_W-1:0], regs_ff.n);
               regs_in.state = ST_TP1;
            end
         end
         ST_TP1: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.cx), MUL_W'(regs_ff.p),
                                '0, MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.t1    = ares.rem[N_W-1:0];
               regs_in.state = ST_TP2;
            end
         end
         ST_TP2: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.t1), MUL_W'(regs_ff.mq),
                                '0, MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.tp    = ares.rem[N_W-1:0];
               regs_in.state = ST_TQ1;
            end
         end
         ST_TQ1: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.cy), MUL_W'(regs_ff.q),
                                '0, MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.t1    = ares.rem[N_W-1:0];
               regs_in.state = ST_TQ2;
            end
         end
         ST_TQ2: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b1, MUL_W'(regs_ff.t1), MUL_W'(regs_ff.mp),
                                '0, MUL_W'(regs_ff.n)};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend  = 1'b0;
               regs_in.tq    = ares.rem[N_W-1:0];
               regs_in.state = ST_COMB;
            end
         end
         ST_COMB: begin
            regs_in.roots[0] = ROOT_W'(rr);
            regs_in.roots[1] = ROOT_W'((rr == '0) ? '0 : regs_ff.n - rr);
            regs_in.roots[2] = ROOT_W'(tt);
            regs_in.roots[3] = ROOT_W'((tt == '0) ? '0 : regs_ff.n - tt);
            regs_in.state    = ST_KN;
         end
         ST_KN: begin
            if (!regs_ff.pend) begin
               regs_in.cmd  = '{1'b1, 1'b1, 1'b0, MUL_W'(regs_ff.k), MUL_W'(regs_ff.n),
                                '0, '0};
               regs_in.pend = 1'b1;
            end else if (ares.done) begin
               regs_in.pend       = 1'b0;
               regs_in.roots[0]   = regs_ff.roots[0] + kn;
               regs_in.roots[1]   = regs_ff.roots[1] + kn;
               regs_in.roots[2]   = regs_ff.roots[2] + kn;
               regs_in.roots[3]   = regs_ff.roots[3] + kn;
               regs_in.res.root_r = regs_ff.roots[0] + kn;
               regs_in.res.root_s = regs_ff.roots[1] + kn;
               regs_in.res.root_t = regs_ff.roots[2] + kn;
               regs_in.res.root_u = regs_ff.roots[3] + kn;
               regs_in.hidx       = '0;
               regs_in.state      = ST_HALF;
            end
         end
         ST_HALF: begin
            if (hr.hit) begin
               regs_in.res.message_out = hr.half;
               regs_in.res.msg_valid   = 1'b1;
               regs_in.state           = ST_DONE;
            end else if (regs_ff.hidx == 2'd3) begin
               regs_in.state = ST_DONE;
            end else begin
               regs_in.hidx = regs_ff.hidx + 2'd1;
            end
         end
         ST_DONE: begin
            if (take_i) regs_in.state = ST_IDLE;
         end
         default: regs_in.state = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.state     <= ST_IDLE;
         regs_ff.pend      <= 1'b0;
         regs_ff.cmd.start <= 1'b0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   red_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd_i (regs_ff.cmd),
      .res_o (ares)
   );

   assign status_o.idle = (regs_ff.state == ST_IDLE);
   assign status_o.done = (regs_ff.state == ST_DONE);
   assign result_o      = regs_ff.res;

endmodule

// ----- test/rabin_encrypt_decrypt_tb.sv -----
// Self-checking testbench for the Rabin cipher block: encrypt and decrypt requests
// checked against a built-in predictor. Depends on red_pkg, red_ifs and the top level.
`timescale 1ns / 1ps
module rabin_encrypt_decrypt_tb;
   import red_pkg::*;

   localparam int LIMIT_CYCLES = 60000000;

   typedef struct {
      logic              op;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] k;
   } cipher_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   red_req_if req_ch ();
   red_rsp_if rsp_ch ();
   red_csr_if csr_ch ();

   rabin_encrypt_decrypt dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   cipher_request_type pending_requests[$];
   red_result_type     expected_results[$];
   logic [CFG_W-1:0] cur_p = PRIME_P_RESET;
   logic [CFG_W-1:0] cur_q = PRIME_Q_RESET;
   int fails = 0;
   int cycles = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;

   always #5 clock = ~clock;

   function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      return ((a % m) * (b % m)) % m;
   endfunction

   function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      base = base % m;
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, base, m);
         base = mod_mul(base, base, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic int bit_len(logic [63:0] v);
      int len;
      len = 0;
      while (v != 0) begin
         len++;
         v = v >> 1;
      end
      return len;
   endfunction

   function automatic logic [63:0] coef_mod(longint v, logic [63:0] m);
      logic [63:0] r;
      if (v >= 0) return 64'(v) % m;
      r = 64'(-v) % m;
      return (r == 0) ? 64'd0 : m - r;
   endfunction

   function automatic red_result_type predict_cipher(logic op, logic [DATA_W-1:0] d,
                                                     logic [DATA_W-1:0] k,
                                                     logic [CFG_W-1:0] p16,
                                                     logic [CFG_W-1:0] q16);
      red_result_type res;
      logic [63:0] p, q, n, m, e, kn, mp, mq, cx, cy, tp, tq, r, s, t, u, root, lo, hi;
      logic [63:0] roots[4];
      longint a, b, x, y, lx, ly, z, rem, tmp;
      int len, h;
      res = '0;
      p = 64'(p16);
      q = 64'(q16);
      n = p * q;
      if (op == OP_ENCRYPT) begin
         m = 64'(d[MSG_BITS-1:0]);
         len = bit_len(m);
         e = (m << len) | m;
         if (n != 0) begin
            res.cipher_out = DATA_W'(mod_mul(e, e, n));
            res.quotient_out = DATA_W'(e / n);
         end
         return res;
      end
      r = 0; s = 0; t = 0; u = 0;
      if (n != 0) begin
         a = longint'(p); b = longint'(q);
         x = 0; y = 1; lx = 1; ly = 0;
         while (b != 0) begin
            z = a / b;
            rem = a % b;
            a = b;
            b = rem;
            tmp = x; x = lx - z * x; lx = tmp;
            tmp = y; y = ly - z * y; ly = tmp;
         end
         mp = mod_pow(64'(d), (p + 1) / 4, p);
         mq = mod_pow(64'(d), (q + 1) / 4, q);
         cx = coef_mod(lx, n);
         cy = coef_mod(ly, n);
         tp = mod_mul(mod_mul(cx, p, n), mq, n);
         tq = mod_mul(mod_mul(cy, q, n), mp, n);
         r = tp + tq;
         if (r >= n) r = r - n;
         t = (tq >= tp) ? tq - tp : tq + (n - tp);
         s = (r == 0) ? 64'd0 : n - r;
         u = (t == 0) ? 64'd0 : n - t;
      end
      kn = 64'(k) * n;
      roots[0] = (kn + r) & 64'h1_FFFF_FFFF;
      roots[1] = (kn + s) & 64'h1_FFFF_FFFF;
      roots[2] = (kn + t) & 64'h1_FFFF_FFFF;
      roots[3] = (kn + u) & 64'h1_FFFF_FFFF;
      res.root_r = ROOT_W'(roots[0]);
      res.root_s = ROOT_W'(roots[1]);
      res.root_t = ROOT_W'(roots[2]);
      res.root_u = ROOT_W'(roots[3]);
      for (int i = 0; i < 4; i++) begin
         root = roots[i];
         len = bit_len(root);
         if (len != 0 && len % 2 == 0) begin
            h = len / 2;
            lo = root & ((64'd1 << h) - 1);
            hi = root >> h;
            if (lo == hi) begin
               res.message_out = HALF_W'(hi);
               res.msg_valid = 1'b1;
               break;
            end
         end
      end
      return res;
   endfunction

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      logic next_valid;
      cipher_request_type item;
      next_valid = req_ch.valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            item = pending_requests.pop_front();
            expected_results = {expected_results,
                                predict_cipher(item.op, item.data, item.k, cur_p, cur_q)};
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               next_valid = 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_valid = 1'b1;
               req_ch.op <= pending_requests[0].op;
               req_ch.data_in <= pending_requests[0].data;
               req_ch.quotient_in <= pending_requests[0].k;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               next_valid = 1'b0;
            end
         end
      end
      req_ch.valid <= next_valid;
   end

   task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         $display("%0t %s expected %0h actual %0h", $time, name, exp, act);
         fails++;
      end
   endtask

   // result monitor and stall pattern
   always @(posedge clock) begin
      red_result_type exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result cipher %0h", $time, rsp_ch.cipher_out);
            fails++;
         end else begin
            exp = expected_results.pop_front();
            check_field("cipher_out", exp.cipher_out, rsp_ch.cipher_out);
            check_field("quotient_out", exp.quotient_out, rsp_ch.quotient_out);
            check_field("root_r", exp.root_r, rsp_ch.root_r);
            check_field("root_s", exp.root_s, rsp_ch.root_s);
            check_field("root_t", exp.root_t, rsp_ch.root_t);
            check_field("root_u", exp.root_u, rsp_ch.root_u);
            check_field("message_out", exp.message_out, rsp_ch.message_out);
            check_field("msg_valid", exp.msg_valid, rsp_ch.msg_valid);
         end
      end
      if (cycles % 500 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("rabin_encrypt_decrypt: mismatch");
         $finish;
      end
   end

   task automatic write_prime(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      forever begin
         @(posedge clock);
         if (csr_ch.ready) break;
      end
      csr_ch.valid <= 1'b0;
      if (idx == REG_PRIME_P) cur_p = value;
      else cur_q = value;
   endtask

   task automatic add_request(logic op, logic [DATA_W-1:0] d, logic [DATA_W-1:0] k);
      cipher_request_type item;
      item.op = op;
      item.data = d;
      item.k = k;
      pending_requests = {pending_requests, item};
   endtask

   // encrypt then decrypt the same message
   task automatic add_round_trip(logic [DATA_W-1:0] msg);
      red_result_type enc;
      enc = predict_cipher(OP_ENCRYPT, msg, '0, cur_p, cur_q);
      add_request(OP_ENCRYPT, msg, $urandom);
      add_request(OP_DECRYPT, enc.cipher_out, enc.quotient_out);
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || expected_results.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic add_random(int count);
      int sel, w;
      logic [DATA_W-1:0] msg;
      logic [63:0] n;
      n = 64'(cur_p) * 64'(cur_q);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         w = $urandom_range(0, 16);
         msg = $urandom & ((32'd1 << w) - 1);
         if ($urandom_range(0, 15) == 0) msg = $urandom;
         if (sel <= 2) add_request(OP_ENCRYPT, msg, $urandom);
         else if (sel <= 7) add_round_trip(msg);
         else if (sel == 8 && n != 0)
            add_request(OP_DECRYPT, DATA_W'(64'($urandom) % n), $urandom_range(0, 300));
         else add_request(OP_DECRYPT, $urandom, $urandom);
      end
   endtask

   initial begin
      logic [CFG_W-1:0] p_set[9] = '{16'd3, 16'd65519, 16'd65535, 16'd0, 16'd1,
                                     16'd7, 16'd47, 16'd251, 16'd43};
      logic [CFG_W-1:0] q_set[9] = '{16'd7, 16'd65503, 16'd65535, 16'd11, 16'd7,
                                     16'd7, 16'd59, 16'd239, 16'd0};
      int per_phase[9] = '{100, 60, 40, 60, 80, 80, 120, 120, 40};
      req_ch.valid = 1'b0;
      req_ch.op = OP_ENCRYPT;
      req_ch.data_in = '0;
      req_ch.quotient_in = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_PRIME_P;
      csr_ch.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_prime(REG_PRIME_P, PRIME_P_RESET);
      write_prime(REG_PRIME_Q, PRIME_Q_RESET);
      add_round_trip(32'd0);
      add_round_trip(32'd1);
      add_round_trip(32'd3);
      add_round_trip(32'hFFFF);
      add_round_trip(32'hFFFF_FFFF);
      add_round_trip(32'hA5A5_0002);
      add_request(OP_DECRYPT, 32'd0, 32'd0);
      add_request(OP_DECRYPT, 32'd252, 32'd0);
      add_request(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(OP_DECRYPT, 32'h5A5A_5A5A, 32'h1234_5678);
      add_request(OP_ENCRYPT, 32'h8000_0000, 32'hFFFF_FFFF);
      add_random(350);
      wait_idle();
      for (int ph = 0; ph < 9; ph++) begin
         write_prime(REG_PRIME_P, p_set[ph]);
         write_prime(REG_PRIME_Q, q_set[ph]);
         add_round_trip(32'd1);
         add_round_trip(32'hFFFF);
         add_random(per_phase[ph]);
         wait_idle();
      end
      if (fails == 0) begin
         $display("rabin_encrypt_decrypt: match");
      end else begin
         $display("rabin_encrypt_decrypt: mismatch");
      end
      $finish;
   end
endmodule
